@@ design/rme_pkg.sv @@
// Shared types and constants for the RSA modular exponentiation block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package rme_pkg;

    localparam int WORD_BITS_DEF = 24;
    localparam int MSG_W         = 24;
    localparam int RES_W         = 24;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS  = 2'd0,
        CFG_PUB_EXP  = 2'd1,
        CFG_PRIV_EXP = 2'd2
    } t_rme_cfg_idx;

    typedef enum logic [1:0] {
        MSEL_REDUCE = 2'd0,
        MSEL_SQUARE = 2'd1,
        MSEL_BASE   = 2'd2
    } t_rme_msel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_RED_WAIT,
        S_SQ,
        S_SQ_WAIT,
        S_MB,
        S_MB_WAIT,
        S_NEXT,
        S_DONE
    } t_rme_state;

    typedef struct packed {
        logic      load;
        logic      mul_start;
        t_rme_msel msel;
        logic      base_load;
        logic      acc_load;
        logic      exp_shift;
        logic      res_load;
    } t_rme_cmd;

    typedef struct packed {
        logic mul_busy;
        logic exp_msb;
        logic mod_small;
    } t_rme_status;

endpackage

@@ design/rme_in_if.sv @@
// Request channel interface: valid, ready and the message payload.
// Depends on rme_pkg for the field widths.
`timescale 1ns / 1ps

interface rme_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [rme_pkg::MSG_W-1:0] message;

    modport source (output valid, output mode, output message, input ready);
    modport sink   (input valid, input mode, input message, output ready);
endinterface

@@ design/rme_out_if.sv @@
// Result channel interface: valid, ready and the result payload.
// Depends on rme_pkg for the field width.
`timescale 1ns / 1ps

interface rme_out_if;
    logic                      valid;
    logic                      ready;
    logic [rme_pkg::RES_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

@@ design/rsa_modular_exponentiation.sv @@
// RSA modular exponentiation, left-to-right square-and-multiply over WORD_BITS exponent bits.
// A modulus below two skips the arithmetic and gives a zero result.
// One request at a time. The bit-serial modular multiplier sets the rate: one multiplier bit
// per cycle. A finished result waits in the output register while the next request is taken.
// Synchronous active-low reset: modulus 2, both exponents 0, channels idle.
`timescale 1ns / 1ps

module rsa_modular_exponentiation #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rme_in_if.sink                        i_in,
    rme_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]          i_cfg_data
);

    rme_pkg::t_rme_cmd    w_cmd;
    rme_pkg::t_rme_status w_status;
    rme_pkg::t_rme_state  w_state;

    rme_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    rme_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_in.mode),
        .i_message   (i_in.message),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_out.result_value)
    );

    // Once a request is taken, no other is taken on the next edge.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while previous one still in progress");

    // The multiplier never runs while the controller is idle.
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == rme_pkg::S_IDLE) |-> !w_status.mul_busy)
        else $error("multiplier busy while controller idle");

    // A multiplication only finishes while the controller waits for it.
    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_status.mul_busy) |-> (w_state == rme_pkg::S_RED_WAIT ||
            w_state == rme_pkg::S_SQ_WAIT || w_state == rme_pkg::S_MB_WAIT))
        else $error("multiplication finished outside a wait state");

endmodule

@@ design/rme_datapath.sv @@
// Datapath: configuration registers, operand registers and a bit-serial
// modular multiplier. Driven by rme_ctrl through rme_pkg command/status structs.
`timescale 1ns / 1ps

module rme_datapath #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]          i_cfg_data,
    input  logic                          i_mode,
    input  logic [rme_pkg::MSG_W-1:0]     i_message,
    input  rme_pkg::t_rme_cmd             i_cmd,
    output rme_pkg::t_rme_status          o_status,
    output logic [rme_pkg::RES_W-1:0]     o_result
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int EXT_W = WORD_BITS + rme_pkg::RES_W;

    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_pub;
    logic [WORD_BITS-1:0] r_priv;

    logic [WORD_BITS-1:0] r_msg;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_exp;
    logic [rme_pkg::RES_W-1:0] r_result;

    logic [WORD_BITS-1:0] r_mx;
    logic [WORD_BITS-1:0] r_my;
    logic [WORD_BITS-1:0] r_macc;
    logic [CNT_W-1:0]     r_mcnt;
    logic                 r_mbusy;

    logic [EXT_W-1:0]     w_msg_ext;
    logic [EXT_W-1:0]     w_acc_ext;
    logic [WORD_BITS-1:0] w_op_x;
    logic [WORD_BITS-1:0] w_op_y;
    logic [WORD_BITS:0]   w_dbl_sum;
    logic [WORD_BITS-1:0] w_dbl;
    logic [WORD_BITS:0]   w_add_sum;
    logic [WORD_BITS-1:0] w_add;
    logic                 w_mod_small;

    // Messages wider than the word are cut to the word; narrower ones are zero-extended.
    assign w_msg_ext   = EXT_W'(i_message);
    assign w_acc_ext   = EXT_W'(r_acc);
    assign w_mod_small = (r_mod[WORD_BITS-1:1] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= WORD_BITS'(2);
            r_pub  <= '0;
            r_priv <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rme_pkg::CFG_MODULUS:  r_mod  <= i_cfg_data;
                rme_pkg::CFG_PUB_EXP:  r_pub  <= i_cfg_data;
                rme_pkg::CFG_PRIV_EXP: r_priv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.msel)
            rme_pkg::MSEL_REDUCE: begin
                w_op_x = WORD_BITS'(1);
                w_op_y = r_msg;
            end
            rme_pkg::MSEL_SQUARE: begin
                w_op_x = r_acc;
                w_op_y = r_acc;
            end
            rme_pkg::MSEL_BASE: begin
                w_op_x = r_acc;
                w_op_y = r_base;
            end
            default: begin
                w_op_x = r_acc;
                w_op_y = r_acc;
            end
        endcase
    end

    // One multiplier bit per cycle: double the partial product, then add x
    // when the current bit of y is set, each step reduced by one subtract.
    always_comb begin
        w_dbl_sum = {1'b0, r_macc} + {1'b0, r_macc};
        if (w_dbl_sum >= {1'b0, r_mod}) begin
            w_dbl = WORD_BITS'(w_dbl_sum - {1'b0, r_mod});
        end else begin
            w_dbl = w_dbl_sum[WORD_BITS-1:0];
        end
        w_add_sum = {1'b0, w_dbl} + {1'b0, r_mx};
        if (w_add_sum >= {1'b0, r_mod}) begin
            w_add = WORD_BITS'(w_add_sum - {1'b0, r_mod});
        end else begin
            w_add = w_add_sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && (r_mcnt == '0)) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mx   <= w_op_x;
            r_my   <= w_op_y;
            r_macc <= '0;
            r_mcnt <= CNT_W'(WORD_BITS - 1);
        end else if (r_mbusy) begin
            r_my   <= r_my << 1;
            r_macc <= r_my[WORD_BITS-1] ? w_add : w_dbl;
            r_mcnt <= r_mcnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_msg <= w_msg_ext[WORD_BITS-1:0];
            r_exp <= i_mode ? r_priv : r_pub;
            r_acc <= WORD_BITS'(1);
        end else begin
            if (i_cmd.acc_load) begin
                r_acc <= r_macc;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= r_exp << 1;
            end
        end
        if (i_cmd.base_load) begin
            r_base <= r_macc;
        end
        if (i_cmd.res_load) begin
            r_result <= w_mod_small ? '0 : w_acc_ext[rme_pkg::RES_W-1:0];
        end
    end

    assign o_status.mul_busy  = r_mbusy;
    assign o_status.exp_msb   = r_exp[WORD_BITS-1];
    assign o_status.mod_small = w_mod_small;
    assign o_result           = r_result;

endmodule

@@ design/rme_ctrl.sv @@
// Controller state machine: sequences reduction, square and multiply steps
// and owns the channel handshakes. Uses rme_pkg types; drives rme_datapath.
`timescale 1ns / 1ps

module rme_ctrl #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  rme_pkg::t_rme_status i_status,
    output rme_pkg::t_rme_cmd    o_cmd,
    output rme_pkg::t_rme_state  o_state
);

    localparam int CNT_W = $clog2(WORD_BITS);

    rme_pkg::t_rme_state r_state, n_state;
    logic [CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rme_pkg::S_IDLE;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.msel  = rme_pkg::MSEL_SQUARE;
        o_in_ready  = 1'b0;

        unique case (r_state)
            rme_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rme_pkg::S_RED;
                end
            end
            rme_pkg::S_RED: begin
                // A modulus below two always gives zero, so skip the arithmetic.
                if (i_status.mod_small) begin
                    n_state = rme_pkg::S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = rme_pkg::MSEL_REDUCE;
                    n_state         = rme_pkg::S_RED_WAIT;
                end
            end
            rme_pkg::S_RED_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.base_load = 1'b1;
                    n_bit_cnt       = CNT_W'(WORD_BITS - 1);
                    n_state         = rme_pkg::S_SQ;
                end
            end
            rme_pkg::S_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = rme_pkg::MSEL_SQUARE;
                n_state         = rme_pkg::S_SQ_WAIT;
            end
            rme_pkg::S_SQ_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.acc_load = 1'b1;
                    n_state = i_status.exp_msb ? rme_pkg::S_MB : rme_pkg::S_NEXT;
                end
            end
            rme_pkg::S_MB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = rme_pkg::MSEL_BASE;
                n_state         = rme_pkg::S_MB_WAIT;
            end
            rme_pkg::S_MB_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.acc_load = 1'b1;
                    n_state        = rme_pkg::S_NEXT;
                end
            end
            rme_pkg::S_NEXT: begin
                o_cmd.exp_shift = 1'b1;
                if (r_bit_cnt == '0) begin
                    n_state = rme_pkg::S_DONE;
                end else begin
                    n_bit_cnt = r_bit_cnt - CNT_W'(1);
                    n_state   = rme_pkg::S_SQ;
                end
            end
            rme_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = rme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rme_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

@@ dv/tb_rsa_modular_exponentiation.sv @@
// Self-checking testbench for rsa_modular_exponentiation: directed table, then random phases.
// Depends on rme_pkg, rme_in_if and rme_out_if; results are checked against the table or a local predictor.
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation;

    localparam int W          = rme_pkg::WORD_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 3000;
    localparam int DRAIN_WAIT = 1400;
    localparam int N_PHASES   = 8;
    localparam int PHASE_REQS = 60;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        bit                        set_keys;
        logic [W-1:0]              modulus;
        logic [W-1:0]              pub_exp;
        logic [W-1:0]              priv_exp;
        logic                      mode;
        logic [rme_pkg::MSG_W-1:0] message;
        bit                        known;
        logic [rme_pkg::RES_W-1:0] result;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rme_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [W-1:0] i_cfg_data;

    rme_in_if  req_if();
    rme_out_if res_if();

    rsa_modular_exponentiation #(.WORD_BITS(W)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the key registers, as written to the block.
    logic [W-1:0] key_modulus;
    logic [W-1:0] key_pub_exp;
    logic [W-1:0] key_priv_exp;

    logic [rme_pkg::RES_W-1:0] pending_results[$];
    int error_cnt   = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit long_hold_pending = 1'b0;

    t_dir_row dir_table [0:N_DIRECTED-1] = '{
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 1'b1, 24'd1},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'hFFFFFF, 1'b1, 24'd1},
        '{1'b1, 24'd0, 24'd5, 24'd9, 1'b0, 24'd12345, 1'b1, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'hFFFFFF, 1'b1, 24'd0},
        '{1'b1, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 24'hFFFFFF, 1'b1, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'd0, 1'b1, 24'd0},
        '{1'b1, 24'd3233, 24'd17, 24'd2753, 1'b0, 24'd65, 1'b1, 24'd2790},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'd2790, 1'b1, 24'd65},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 1'b1, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'hFFFFFF, 1'b0, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'd3233, 1'b1, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'd3232, 1'b0, 24'd0},
        '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 1'b0, 24'hFFFFFF, 1'b1, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'd123456, 1'b1, 24'd1},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'hFFFFFE, 1'b0, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd1, 1'b1, 24'd1},
        '{1'b1, 24'd2, 24'd1, 24'hFFFFFF, 1'b0, 24'd3, 1'b1, 24'd1},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'hFFFFFE, 1'b1, 24'd0},
        '{1'b1, 24'hFFFFFD, 24'h800000, 24'd1, 1'b0, 24'hABCDEF, 1'b0, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, 24'hABCDEF, 1'b1, 24'hABCDEF},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'h555555, 1'b0, 24'd0},
        '{1'b1, 24'h00A5A5, 24'h5A5A5A, 24'hA5A5A5, 1'b1, 24'h5A5A5A, 1'b0, 24'd0},
        '{1'b0, 24'd0, 24'd0, 24'd0, 1'b0, 24'hA5A5A5, 1'b0, 24'd0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Square-and-multiply over all W exponent bits, most significant first.
    function automatic logic [rme_pkg::RES_W-1:0] modexp_predict(
            input logic mode, input logic [rme_pkg::MSG_W-1:0] message);
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        logic [W-1:0] e;
        m   = key_modulus;
        e   = mode ? key_priv_exp : key_pub_exp;
        acc = 1;
        if (m < 2) begin
            return '0;
        end
        b = message % m;
        for (int i = W - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (e[i]) begin
                acc = (acc * b) % m;
            end
        end
        return acc[rme_pkg::RES_W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_modulus();
        case ($urandom_range(0, 9))
            0: return W'($urandom_range(0, 1));
            1: return '1;
            2: return W'(2);
            3: return W'($urandom_range(3, 1000));
            default: return W'($urandom_range(2, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [W-1:0] rand_exponent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return W'($urandom_range(1, 255));
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [rme_pkg::MSG_W-1:0] rand_message();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return rme_pkg::MSG_W'(key_modulus - 1'b1);
            3: return rme_pkg::MSG_W'(key_modulus);
            default: return rme_pkg::MSG_W'($urandom);
        endcase
    endfunction

    // Offers one request and records its expected result once it is taken.
    task automatic send_request(input logic mode, input logic [rme_pkg::MSG_W-1:0] message,
                                input bit known, input logic [rme_pkg::RES_W-1:0] result);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.message <= message;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(known ? result : modexp_predict(mode, message));
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_key(input rme_pkg::t_rme_cfg_idx index, input logic [W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (index)
            rme_pkg::CFG_MODULUS:  key_modulus  = value;
            rme_pkg::CFG_PUB_EXP:  key_pub_exp  = value;
            rme_pkg::CFG_PRIV_EXP: key_priv_exp = value;
            default: ;
        endcase
    endtask

    task automatic load_keys(input logic [W-1:0] modulus, input logic [W-1:0] pub_exp,
                             input logic [W-1:0] priv_exp);
        wait_all_results();
        write_key(rme_pkg::CFG_MODULUS, modulus);
        write_key(rme_pkg::CFG_PUB_EXP, pub_exp);
        write_key(rme_pkg::CFG_PRIV_EXP, priv_exp);
        i_cfg_we <= 1'b0;
    endtask

    // Result sink: random stalls, plus one long hold-off so the block backs up.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_stall_pct) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [rme_pkg::RES_W-1:0] want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                error_cnt++;
                if (error_cnt <= 10) begin
                    $display("result %h arrived with no request pending", res_if.result_value);
                end
            end else begin
                want = pending_results.pop_front();
                if (res_if.result_value !== want) begin
                    error_cnt++;
                    if (error_cnt <= 10) begin
                        $display("result_value mismatch: expected %h, got %h",
                                 want, res_if.result_value);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) || i_cfg_we === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_rsa_modular_exponentiation: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row row;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= 1'b0;
        req_if.message <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= rme_pkg::CFG_MODULUS;
        i_cfg_data     <= '0;
        key_modulus  = W'(2);
        key_pub_exp  = '0;
        key_priv_exp = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first rows run on the reset keys before anything is written.
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = dir_table[r];
            if (row.set_keys) begin
                load_keys(row.modulus, row.pub_exp, row.priv_exp);
            end
            send_request(row.mode, row.message, row.known, row.result);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_keys(rand_modulus(), rand_exponent(), rand_exponent());
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            if (ph == 4) begin
                long_hold_pending = 1'b1;
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                send_request(1'($urandom_range(0, 1)), rand_message(), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        error_cnt += pending_results.size();
        if (error_cnt == 0) begin
            $display("tb_rsa_modular_exponentiation: clean");
        end else begin
            $display("tb_rsa_modular_exponentiation: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/rme_pkg.sv
design/rme_in_if.sv
design/rme_out_if.sv
design/rme_datapath.sv
design/rme_ctrl.sv
design/rsa_modular_exponentiation.sv
dv/tb_rsa_modular_exponentiation.sv
